// ===== hdl/cbm_pkg.sv =====
// Shared types, target codes and constants for the cartridge bank mapper.
`timescale 1ns / 1ps
package cbm_pkg;

    localparam int unsigned CHR_RAM_BYTES = 16384;

    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM = 3'd3;
    localparam logic [2:0] TGT_CHR_RAM = 3'd4;

    localparam logic [1:0] CMD_CPU_RD = 2'd0;
    localparam logic [1:0] CMD_CPU_WR = 2'd1;
    localparam logic [1:0] CMD_PPU_RD = 2'd2;
    localparam logic [1:0] CMD_PPU_WR = 2'd3;

    localparam logic [2:0] REG_MAPPER    = 3'd0;
    localparam logic [2:0] REG_PRG_ROM   = 3'd1;
    localparam logic [2:0] REG_CHR_ROM   = 3'd2;
    localparam logic [2:0] REG_PRG_RAM   = 3'd3;
    localparam logic [2:0] REG_CHR_RAM   = 3'd4;
    localparam logic [2:0] REG_INIT_MIR  = 3'd5;
    localparam logic [2:0] REG_PRG_COUNT = 3'd6;

    localparam int unsigned NUM_BANKS = 11;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  target;
        logic [25:0] offset;
        logic        ram_write;
        logic        mirroring;
        logic        irq_enabled;
        logic [7:0]  irq_reload_value;
        logic        irq_reload_pending;
        logic        irq_counter_clear;
    } t_out_beat;

    typedef struct packed {
        logic [11:0] mapper_number;
        logic [25:0] prg_rom_bytes;
        logic [24:0] chr_rom_bytes;
        logic [21:0] prg_ram_bytes;
        logic        chr_ram_present;
        logic        initial_mirroring;
        logic [7:0]  prg_count_low_byte;
    } t_cfg;

    typedef struct packed {
        logic [7:0] shift_or_select;
        logic [2:0] shift_count;
        logic [4:0] serial_control;
        logic       mirror_mode;
        logic [7:0] irq_reload_reg;
        logic       irq_latch_flag;
        logic       irq_enable_flag;
    } t_misc_state;

    typedef logic [NUM_BANKS-1:0][7:0] t_banks;

endpackage

// ===== hdl/cartridge_bank_mapper_core.sv =====
// Top level of the cartridge bank mapper.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_beat) carries one CPU or PPU
//   bus access per beat. Output channel (o_out_valid / i_out_stall /
//   o_out_beat) returns one result beat per access: target memory, byte
//   offset, RAM write strobe, mirroring and interrupt set-up state.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes registers 0..6; any write reloads the mapper state from the new
//   settings in the next cycle. Write config only while the block is idle.
//   The output is registered: a result is valid in the cycle after accept.
//   Throughput: one access per cycle unless stalled; translation and register
//   update are one level of logic between register bank and output register.
//   Stall: while the receiver stalls, the output register holds its beat and
//   o_in_stall is raised, so no access is accepted until the beat is taken.
//   Reset (synchronous, active low) loads default config and mapper state
//   and empties the output register.
module cartridge_bank_mapper_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cbm_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cbm_pkg::t_out_beat o_out_beat,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import cbm_pkg::*;

    t_cfg        cfg;
    logic        reload;
    t_banks      banks;
    t_misc_state misc;
    logic        clr;
    logic        step;
    logic [2:0]  tgt;
    logic [25:0] off;
    logic        wr;
    logic        r_valid;
    t_out_beat   r_out;

    assign o_in_stall = r_valid && i_out_stall;
    assign step       = i_in_valid && !o_in_stall;

    cbm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_reload    (reload)
    );

    cbm_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_reload (reload),
        .i_step   (step),
        .i_beat   (i_in_beat),
        .o_banks  (banks),
        .o_misc   (misc),
        .o_clear  (clr)
    );

    cbm_translate u_xlat (
        .i_cfg       (cfg),
        .i_banks     (banks),
        .i_beat      (i_in_beat),
        .o_target    (tgt),
        .o_offset    (off),
        .o_ram_write (wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.target             <= tgt;
            r_out.offset             <= off;
            r_out.ram_write          <= wr;
            r_out.mirroring          <= misc.mirror_mode;
            r_out.irq_enabled        <= misc.irq_enable_flag;
            r_out.irq_reload_value   <= misc.irq_reload_reg;
            r_out.irq_reload_pending <= misc.irq_latch_flag;
            r_out.irq_counter_clear  <= clr;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_beat  = r_out;
endmodule

// ===== hdl/cbm_translate.sv =====
// Address translation: bus access plus bank state to target and offset.
`timescale 1ns / 1ps
module cbm_translate (
    input  cbm_pkg::t_cfg     i_cfg,
    input  cbm_pkg::t_banks   i_banks,
    input  cbm_pkg::t_in_beat i_beat,
    output logic [2:0]        o_target,
    output logic [25:0]       o_offset,
    output logic              o_ram_write
);
    import cbm_pkg::*;

    logic [15:0] a;
    logic [27:0] off;
    logic [27:0] size;
    logic [2:0]  tgt;
    logic        wr;
    logic        hit;
    logic [27:0] prg;

    always_comb begin
        a    = i_beat.address;
        prg  = {2'b0, i_cfg.prg_rom_bytes};
        off  = '0;
        size = '0;
        tgt  = TGT_NONE;
        wr   = 1'b0;
        case (i_beat.command)
            CMD_CPU_RD: begin
                case (i_cfg.mapper_number)
                    12'd0, 12'd3: begin
                        if (a >= 16'h8000) begin
                            tgt  = TGT_PRG_ROM;
                            size = prg;
                            if (a < 16'hC000 || i_cfg.prg_count_low_byte > 8'd1)
                                off = {12'b0, a - 16'h8000};
                            else
                                off = {12'b0, a - 16'hC000};
                        end
                    end
                    12'd1: begin
                        if (a >= 16'h6000 && a < 16'h8000) begin
                            tgt  = TGT_PRG_RAM;
                            size = {6'b0, i_cfg.prg_ram_bytes};
                            off  = {12'b0, a - 16'h6000};
                        end else if (a >= 16'h8000) begin
                            tgt  = TGT_PRG_ROM;
                            size = prg;
                            off  = {6'b0, (a < 16'hC000) ? i_banks[0] : i_banks[1],
                                    a[13:0]};
                        end
                    end
                    12'd2: begin
                        if (a >= 16'h8000 && a < 16'hC000) begin
                            tgt  = TGT_PRG_ROM;
                            size = prg;
                            off  = {6'b0, i_banks[0], a[13:0]};
                        end else if (a >= 16'hC000 && prg >= 28'h4000) begin
                            tgt  = TGT_PRG_ROM;
                            size = prg;
                            off  = prg - 28'h4000 + {14'b0, a[13:0]};
                        end
                    end
                    12'd4: begin
                        if (a >= 16'h6000 && a < 16'h8000) begin
                            tgt  = TGT_PRG_RAM;
                            size = {6'b0, i_cfg.prg_ram_bytes};
                            off  = {12'b0, a - 16'h6000};
                        end else if (a >= 16'h8000 && a < 16'hE000) begin
                            tgt  = TGT_PRG_ROM;
                            size = prg;
                            off  = {7'b0, i_banks[4'd8 + {2'b0, a[14:13]}], a[12:0]};
                        end else if (a >= 16'hE000 && prg >= 28'h2000) begin
                            tgt  = TGT_PRG_ROM;
                            size = prg;
                            off  = prg - 28'h2000 + {15'b0, a[12:0]};
                        end
                    end
                    default: ;
                endcase
            end
            CMD_CPU_WR: begin
                if ((i_cfg.mapper_number == 12'd1 || i_cfg.mapper_number == 12'd4)
                    && a >= 16'h6000 && a < 16'h8000) begin
                    tgt  = TGT_PRG_RAM;
                    size = {6'b0, i_cfg.prg_ram_bytes};
                    off  = {12'b0, a - 16'h6000};
                    wr   = 1'b1;
                end
            end
            CMD_PPU_RD: begin
                if (a < 16'h2000) begin
                    tgt  = TGT_CHR_ROM;
                    size = {3'b0, i_cfg.chr_rom_bytes};
                    case (i_cfg.mapper_number)
                        12'd0: off = {12'b0, a};
                        12'd1: off = {8'b0, i_banks[4'd2 + {3'b0, a[12]}], a[11:0]};
                        12'd2: begin
                            off = {12'b0, a};
                            if (i_cfg.chr_ram_present) begin
                                tgt  = TGT_CHR_RAM;
                                size = 28'(CHR_RAM_BYTES);
                            end
                        end
                        12'd3: off = {7'b0, i_banks[0], a[12:0]};
                        12'd4: off = {10'b0, i_banks[{1'b0, a[12:10]}], a[9:0]};
                        default: tgt = TGT_NONE;
                    endcase
                end
            end
            default: begin
                if (i_cfg.mapper_number == 12'd2 && i_cfg.chr_ram_present
                    && a < 16'h2000) begin
                    tgt  = TGT_CHR_RAM;
                    size = 28'(CHR_RAM_BYTES);
                    off  = {12'b0, a};
                    wr   = 1'b1;
                end
            end
        endcase
        hit = (tgt != TGT_NONE) && (off < size);
        o_target    = hit ? tgt : TGT_NONE;
        o_offset    = hit ? off[25:0] : 26'd0;
        o_ram_write = hit && wr;
    end
endmodule

// ===== hdl/cbm_regs.sv =====
// Bank, serial, select, mirroring and interrupt set-up registers.
`timescale 1ns / 1ps
module cbm_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbm_pkg::t_cfg       i_cfg,
    input  logic                i_reload,
    input  logic                i_step,
    input  cbm_pkg::t_in_beat   i_beat,
    output cbm_pkg::t_banks     o_banks,
    output cbm_pkg::t_misc_state o_misc,
    output logic                o_clear
);
    import cbm_pkg::*;

    t_banks      r_banks, n_banks, rst_banks;
    t_misc_state r_misc, n_misc, rst_misc;
    logic        clr;
    logic [15:0] a;
    logic [7:0]  v;
    logic [2:0]  cnt;
    logic [4:0]  s;
    logic [3:0]  base;
    logic [7:0]  last16;
    logic [7:0]  last8;

    assign last16 = 8'(i_cfg.prg_rom_bytes[25:14] - 12'd1);
    assign last8  = 8'(i_cfg.prg_rom_bytes[25:13] - 13'd2);

    always_comb begin
        rst_banks = '0;
        if (i_cfg.mapper_number == 12'd1) rst_banks[1] = last16;
        else if (i_cfg.mapper_number == 12'd4) rst_banks[10] = last8;
        rst_misc = '0;
        rst_misc.mirror_mode = i_cfg.initial_mirroring;
    end

    always_comb begin
        n_banks = r_banks;
        n_misc  = r_misc;
        clr     = 1'b0;
        a       = i_beat.address;
        v       = i_beat.write_data;
        cnt     = '0;
        s       = '0;
        base    = '0;
        if (i_beat.command == CMD_CPU_WR) begin
            case (i_cfg.mapper_number)
                12'd1: begin
                    if (a >= 16'h8000) begin
                        if (v[7]) begin
                            n_misc.shift_or_select = '0;
                            n_misc.shift_count     = '0;
                        end else begin
                            cnt = (r_misc.shift_count > 3'd4) ? 3'd4 : r_misc.shift_count;
                            s   = r_misc.shift_or_select[4:0] | 5'({4'b0, v[0]} << cnt);
                            n_misc.shift_or_select = {3'b0, s};
                            n_misc.shift_count     = cnt + 3'd1;
                            if (cnt == 3'd4) begin
                                n_misc.shift_or_select = '0;
                                n_misc.shift_count     = '0;
                                case (a[14:13])
                                    2'd0: begin
                                        n_misc.serial_control = s;
                                        if (s[1:0] == 2'd2) n_misc.mirror_mode = 1'b1;
                                        else if (s[1:0] == 2'd3) n_misc.mirror_mode = 1'b0;
                                    end
                                    2'd1: begin
                                        if (r_misc.serial_control[4]) begin
                                            n_banks[2] = {3'b0, s};
                                        end else begin
                                            n_banks[2] = {3'b0, s[4:1], 1'b0};
                                            n_banks[3] = {3'b0, s[4:1], 1'b1};
                                        end
                                    end
                                    2'd2: begin
                                        if (r_misc.serial_control[4]) n_banks[3] = {3'b0, s};
                                    end
                                    default: begin
                                        case (r_misc.serial_control[3:2])
                                            2'd0, 2'd1: begin
                                                n_banks[0] = {4'b0, s[3:1], 1'b0};
                                                n_banks[1] = {4'b0, s[3:1], 1'b1};
                                            end
                                            2'd2: begin
                                                n_banks[0] = '0;
                                                n_banks[1] = {4'b0, s[3:0]};
                                            end
                                            default: begin
                                                n_banks[0] = {4'b0, s[3:0]};
                                                n_banks[1] = last16;
                                            end
                                        endcase
                                    end
                                endcase
                            end
                        end
                    end
                end
                12'd2, 12'd3: begin
                    if (a >= 16'h8000) n_banks[0] = v;
                end
                12'd4: begin
                    if (a >= 16'h8000 && a < 16'hA000) begin
                        if (a[0]) begin
                            case (r_misc.shift_or_select[2:0])
                                3'd0, 3'd1: begin
                                    base = {1'b0, r_misc.shift_or_select[7], 1'b0, 1'b0}
                                         + {2'b0, r_misc.shift_or_select[0], 1'b0};
                                    n_banks[base]        = {v[7:1], 1'b0};
                                    n_banks[base + 4'd1] = {v[7:1], 1'b1};
                                end
                                3'd6: begin
                                    if (r_misc.shift_or_select[6]) n_banks[10] = {2'b0, v[5:0]};
                                    else n_banks[8] = {2'b0, v[5:0]};
                                end
                                3'd7: n_banks[9] = {2'b0, v[5:0]};
                                default: begin
                                    base = (r_misc.shift_or_select[7] ? 4'd0 : 4'd4)
                                         + {1'b0, r_misc.shift_or_select[2:0]} - 4'd2;
                                    n_banks[base] = v;
                                end
                            endcase
                        end else begin
                            if (r_misc.shift_or_select[6] != v[6]) begin
                                n_banks[8]  = r_banks[10];
                                n_banks[10] = r_banks[8];
                            end
                            n_misc.shift_or_select = v;
                        end
                    end else if (a >= 16'hA000 && a < 16'hC000) begin
                        if (!a[0]) n_misc.mirror_mode = ~v[0];
                    end else if (a >= 16'hC000 && a < 16'hE000) begin
                        if (a[0]) begin
                            n_misc.irq_latch_flag = 1'b1;
                            clr = 1'b1;
                        end else begin
                            n_misc.irq_reload_reg = v;
                        end
                    end else if (a >= 16'hE000) begin
                        n_misc.irq_enable_flag = a[0];
                    end
                end
                default: ;
            endcase
        end
    end

    // reset loads the state of the default settings: mapper 0, mirroring 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_banks <= '0;
            r_misc  <= '0;
        end else if (i_reload) begin
            r_banks <= rst_banks;
            r_misc  <= rst_misc;
        end else if (i_step) begin
            r_banks <= n_banks;
            r_misc  <= n_misc;
        end
    end

    assign o_banks = r_banks;
    assign o_misc  = n_misc;
    assign o_clear = clr;
endmodule

// ===== hdl/cbm_cfg.sv =====
// Configuration register file with reload strobe.
`timescale 1ns / 1ps
module cbm_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output cbm_pkg::t_cfg o_cfg,
    output logic          o_reload
);
    import cbm_pkg::*;

    t_cfg r_cfg;
    logic r_reload;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mapper_number      <= 12'd0;
            r_cfg.prg_rom_bytes      <= 26'd32768;
            r_cfg.chr_rom_bytes      <= 25'd8192;
            r_cfg.prg_ram_bytes      <= 22'd8192;
            r_cfg.chr_ram_present    <= 1'b0;
            r_cfg.initial_mirroring  <= 1'b0;
            r_cfg.prg_count_low_byte <= 8'd2;
            r_reload                 <= 1'b0;
        end else begin
            r_reload <= i_cfg_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MAPPER:    r_cfg.mapper_number      <= i_cfg_data[11:0];
                    REG_PRG_ROM:   r_cfg.prg_rom_bytes      <= i_cfg_data[25:0];
                    REG_CHR_ROM:   r_cfg.chr_rom_bytes      <= i_cfg_data[24:0];
                    REG_PRG_RAM:   r_cfg.prg_ram_bytes      <= i_cfg_data[21:0];
                    REG_CHR_RAM:   r_cfg.chr_ram_present    <= i_cfg_data[0];
                    REG_INIT_MIR:  r_cfg.initial_mirroring  <= i_cfg_data[0];
                    REG_PRG_COUNT: r_cfg.prg_count_low_byte <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg    = r_cfg;
    assign o_reload = r_reload;
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the cartridge bank mapper core.
`timescale 1ns / 1ps
module tb;
    import cbm_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_beat   in_beat = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_beat  out_beat;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    cartridge_bank_mapper_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_beat(in_beat),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_beat(out_beat),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mapper settings and register file mirrored by the predictor
    t_cfg        cfg;
    logic [7:0]  banks [NUM_BANKS];
    logic [7:0]  sel_shift;
    logic [2:0]  sh_cnt;
    logic [4:0]  ctrl;
    logic        mir;
    logic [7:0]  ctr_reload_val;
    logic        ctr_pend;
    logic        irq_en;

    t_out_beat   expected_beats[$];
    int          mismatches = 0;
    int          unexpected = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off = 1'b0;

    t_out_beat   acc;

    function automatic logic [7:0] prg_banks16();
        return 8'((cfg.prg_rom_bytes / 32'h4000) - 1);
    endfunction

    function automatic void reload_state();
        foreach (banks[k]) banks[k] = '0;
        sel_shift = '0; sh_cnt = '0; ctrl = '0;
        ctr_reload_val = '0; ctr_pend = 1'b0; irq_en = 1'b0;
        mir = cfg.initial_mirroring;
        if (cfg.mapper_number == 12'd1) banks[1] = prg_banks16();
        else if (cfg.mapper_number == 12'd4)
            banks[10] = 8'((cfg.prg_rom_bytes / 32'h2000) - 2);
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_MAPPER:    cfg.mapper_number = val[11:0];
            REG_PRG_ROM:   cfg.prg_rom_bytes = val[25:0];
            REG_CHR_ROM:   cfg.chr_rom_bytes = val[24:0];
            REG_PRG_RAM:   cfg.prg_ram_bytes = val[21:0];
            REG_CHR_RAM:   cfg.chr_ram_present = val[0];
            REG_INIT_MIR:  cfg.initial_mirroring = val[0];
            REG_PRG_COUNT: cfg.prg_count_low_byte = val[7:0];
            default: ;
        endcase
        reload_state();
    endfunction

    function automatic void land(longint off, longint size, logic [2:0] tgt);
        if (off < size) begin
            acc.target = tgt;
            acc.offset = off[25:0];
        end
    endfunction

    function automatic void map_cpu_read(int a);
        longint prg;
        prg = cfg.prg_rom_bytes;
        case (cfg.mapper_number)
            0, 3: if (a >= 'h8000) begin
                if (a < 'hC000 || cfg.prg_count_low_byte > 1) land(a - 'h8000, prg, TGT_PRG_ROM);
                else land(a - 'hC000, prg, TGT_PRG_ROM);
            end
            1: if (a >= 'h6000) begin
                if (a < 'h8000) land(a - 'h6000, cfg.prg_ram_bytes, TGT_PRG_RAM);
                else land((a & 'h3FFF) + 64'h4000 * banks[a < 'hC000 ? 0 : 1], prg, TGT_PRG_ROM);
            end
            2: if (a >= 'h8000) begin
                if (a < 'hC000) land((a - 'h8000) + 64'h4000 * banks[0], prg, TGT_PRG_ROM);
                else if (prg >= 'h4000) land(prg - 'h4000 + (a - 'hC000), prg, TGT_PRG_ROM);
            end
            4: if (a >= 'h6000) begin
                if (a < 'h8000) land(a - 'h6000, cfg.prg_ram_bytes, TGT_PRG_RAM);
                else if (a < 'hE000)
                    land((a & 'h1FFF) + 64'h2000 * banks[8 + ((a - 'h8000) >> 13)], prg, TGT_PRG_ROM);
                else if (prg >= 'h2000) land(prg - 'h2000 + (a & 'h1FFF), prg, TGT_PRG_ROM);
            end
            default: ;
        endcase
    endfunction

    function automatic void map_ppu_read(int a);
        longint chr;
        chr = cfg.chr_rom_bytes;
        if (a < 'h2000) begin
            case (cfg.mapper_number)
                0: land(a, chr, TGT_CHR_ROM);
                1: land((a & 'hFFF) + 64'h1000 * banks[2 + (a >> 12)], chr, TGT_CHR_ROM);
                2: if (cfg.chr_ram_present) land(a, CHR_RAM_BYTES, TGT_CHR_RAM);
                   else land(a, chr, TGT_CHR_ROM);
                3: land(a + 64'h2000 * banks[0], chr, TGT_CHR_ROM);
                4: land((a & 'h3FF) + 64'h400 * banks[a >> 10], chr, TGT_CHR_ROM);
                default: ;
            endcase
        end
    endfunction

    function automatic void serial_write(int a, logic [7:0] v);
        logic [7:0] s;
        if (v[7]) begin
            sel_shift = '0; sh_cnt = '0;
            return;
        end
        if (sh_cnt > 4) sh_cnt = 3'd4;
        sel_shift = (sel_shift | (8'(v[0]) << sh_cnt)) & 8'h1F;
        if (sh_cnt != 4) begin
            sh_cnt++;
            return;
        end
        s = sel_shift;
        case ((a >> 13) & 3)
            0: begin
                ctrl = s[4:0];
                if (s[1:0] == 2'd2) mir = 1'b1;
                else if (s[1:0] == 2'd3) mir = 1'b0;
            end
            1: if (ctrl[4]) banks[2] = s;
               else begin banks[2] = s & 8'hFE; banks[3] = s | 8'h01; end
            2: if (ctrl[4]) banks[3] = s;
            default: case (ctrl[3:2])
                0, 1: begin banks[0] = s & 8'h0E; banks[1] = (s & 8'h0F) | 8'h01; end
                2: begin banks[0] = '0; banks[1] = s & 8'h0F; end
                default: begin banks[0] = s & 8'h0F; banks[1] = prg_banks16(); end
            endcase
        endcase
        sel_shift = '0; sh_cnt = '0;
    endfunction

    function automatic void select_write(int a, logic [7:0] v);
        logic        odd;
        logic [7:0]  t;
        int          base;
        int          sel;
        odd = a[0];
        if (a < 'hA000) begin
            if (odd) begin
                sel = sel_shift[2:0];
                if (sel <= 1) begin
                    base = (sel_shift[7] ? 4 : 0) + 2 * sel;
                    banks[base] = v & 8'hFE;
                    banks[base + 1] = v | 8'h01;
                end else if (sel <= 5) banks[(sel_shift[7] ? 0 : 4) + sel - 2] = v;
                else if (sel == 6) banks[sel_shift[6] ? 10 : 8] = v & 8'h3F;
                else banks[9] = v & 8'h3F;
            end else begin
                if (sel_shift[6] != v[6]) begin
                    t = banks[8]; banks[8] = banks[10]; banks[10] = t;
                end
                sel_shift = v;
            end
        end else if (a < 'hC000) begin
            if (!odd) mir = ~v[0];
        end else if (a < 'hE000) begin
            if (odd) begin ctr_pend = 1'b1; acc.irq_counter_clear = 1'b1; end
            else ctr_reload_val = v;
        end else irq_en = odd;
    endfunction

    function automatic t_out_beat translate_access(t_in_beat b);
        int a;
        a = b.address;
        acc = '0;
        case (b.command)
            CMD_CPU_RD: map_cpu_read(a);
            CMD_PPU_RD: map_ppu_read(a);
            CMD_CPU_WR: case (cfg.mapper_number)
                1, 4: if (a >= 'h6000) begin
                    if (a < 'h8000) begin
                        land(a - 'h6000, cfg.prg_ram_bytes, TGT_PRG_RAM);
                        acc.ram_write = (acc.target == TGT_PRG_RAM);
                    end else if (cfg.mapper_number == 1) serial_write(a, b.write_data);
                    else select_write(a, b.write_data);
                end
                2, 3: if (a >= 'h8000) banks[0] = b.write_data;
                default: ;
            endcase
            default: if (cfg.mapper_number == 2 && cfg.chr_ram_present && a < 'h2000) begin
                land(a, CHR_RAM_BYTES, TGT_CHR_RAM);
                acc.ram_write = (acc.target == TGT_CHR_RAM);
            end
        endcase
        if (acc.target == TGT_NONE) acc.offset = '0;
        acc.mirroring = mir;
        acc.irq_enabled = irq_en;
        acc.irq_reload_value = ctr_reload_val;
        acc.irq_reload_pending = ctr_pend;
        return acc;
    endfunction

    // result checker
    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_beats.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result beat %h", out_beat);
            end else begin
                want = expected_beats.pop_front();
                if (out_beat !== want) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: exp tgt=%0d off=%h wr=%b mir=%b en=%b rl=%h pend=%b clr=%b",
                                 want.target, want.offset, want.ram_write, want.mirroring,
                                 want.irq_enabled, want.irq_reload_value,
                                 want.irq_reload_pending, want.irq_counter_clear,
                                 "\n          got tgt=%0d off=%h wr=%b mir=%b en=%b rl=%h pend=%b clr=%b",
                                 out_beat.target, out_beat.offset, out_beat.ram_write,
                                 out_beat.mirroring, out_beat.irq_enabled,
                                 out_beat.irq_reload_value, out_beat.irq_reload_pending,
                                 out_beat.irq_counter_clear);
                end
            end
        end
    end

    // receiver stall, random or a long hold-off
    always @(negedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // valid stays up after the accepting edge; the next beat replaces the beat (or idles) or drain() drops it
    task automatic send_beat(t_in_beat b);
        while (($urandom_range(99) < send_idle_pct)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        expected_beats.push_back(translate_access(b));
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        apply_cfg(idx, val);
        @(negedge clk);
    endtask

    function automatic t_in_beat mk(logic [1:0] c, logic [15:0] a, logic [7:0] d);
        t_in_beat b;
        b.command = c; b.address = a; b.write_data = d;
        return b;
    endfunction

    // random accesses of any command, biased to register, PRG RAM and pattern addresses
    function automatic t_in_beat rand_access();
        logic [15:0] a;
        int          r;
        r = $urandom_range(99);
        a = 16'($urandom);
        if (r < 30) a = 16'h8000 | (a & 16'h6001);
        else if (r < 45) a = 16'h6000 | (a & 16'h1FFF);
        else if (r < 65) a = a & 16'h1FFF;
        return mk(2'($urandom), a, 8'(($urandom_range(3) == 0) ? $urandom : $urandom_range(15)));
    endfunction

    typedef struct {
        t_in_beat  beat;
        bit        fixed;
        logic [2:0] tgt;
        logic [25:0] off;
    } t_row;

    t_row directed_rows[$];
    int   pass_no;

    initial begin
        int k;
        cfg = '0;
        cfg.prg_rom_bytes = 32768; cfg.chr_rom_bytes = 8192;
        cfg.prg_ram_bytes = 8192; cfg.prg_count_low_byte = 2;
        reload_state();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: mapper 0 defaults
        directed_rows = '{
            '{mk(CMD_CPU_RD, 16'h8000, 8'h00), 1, TGT_PRG_ROM, 26'h0},
            '{mk(CMD_CPU_RD, 16'hFFFF, 8'h00), 1, TGT_PRG_ROM, 26'h7FFF},
            '{mk(CMD_CPU_RD, 16'h0000, 8'h00), 1, TGT_NONE, 26'h0},
            '{mk(CMD_CPU_RD, 16'h7FFF, 8'h00), 1, TGT_NONE, 26'h0},
            '{mk(CMD_PPU_RD, 16'h0000, 8'h00), 1, TGT_CHR_ROM, 26'h0},
            '{mk(CMD_PPU_RD, 16'h1FFF, 8'h00), 1, TGT_CHR_ROM, 26'h1FFF},
            '{mk(CMD_PPU_RD, 16'h2000, 8'h00), 1, TGT_NONE, 26'h0},
            '{mk(CMD_CPU_WR, 16'hFFFF, 8'hFF), 1, TGT_NONE, 26'h0},
            '{mk(CMD_PPU_WR, 16'h0000, 8'hAA), 1, TGT_NONE, 26'h0}
        };
        foreach (directed_rows[n]) begin
            if (directed_rows[n].fixed) begin
                t_out_beat p;
                p = translate_access(directed_rows[n].beat);
                if (p.target !== directed_rows[n].tgt || p.offset !== directed_rows[n].off) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("directed row %0d: exp tgt=%0d off=%h got tgt=%0d off=%h",
                                 n, directed_rows[n].tgt, directed_rows[n].off,
                                 p.target, p.offset);
                end
                // predictor call above changed nothing for these rows
            end
            send_beat(directed_rows[n].beat);
        end
        drain();

        // mapper 4: select, bank data, mirroring, irq, ram write
        write_reg(REG_MAPPER, 32'd4);
        send_beat(mk(CMD_CPU_WR, 16'h8000, 8'h46));
        send_beat(mk(CMD_CPU_WR, 16'h8001, 8'hFF));
        send_beat(mk(CMD_CPU_WR, 16'h8000, 8'h80));
        send_beat(mk(CMD_CPU_WR, 16'h8001, 8'h03));
        send_beat(mk(CMD_CPU_WR, 16'hA000, 8'h00));
        send_beat(mk(CMD_CPU_WR, 16'hA001, 8'hFF));
        send_beat(mk(CMD_CPU_WR, 16'hC000, 8'hFF));
        send_beat(mk(CMD_CPU_WR, 16'hC001, 8'h00));
        send_beat(mk(CMD_CPU_WR, 16'hE001, 8'h00));
        send_beat(mk(CMD_CPU_WR, 16'h7FFF, 8'h55));
        send_beat(mk(CMD_CPU_RD, 16'hE000, 8'h00));
        send_beat(mk(CMD_PPU_RD, 16'h1C00, 8'h00));
        drain();
        // mapper 1: serial load with reset bit
        write_reg(REG_MAPPER, 32'd1);
        send_beat(mk(CMD_CPU_WR, 16'h8000, 8'h80));
        for (k = 0; k < 5; k++) send_beat(mk(CMD_CPU_WR, 16'h8000, 8'(k == 1)));
        for (k = 0; k < 5; k++) send_beat(mk(CMD_CPU_WR, 16'hE000, 8'(k == 0)));
        send_beat(mk(CMD_CPU_RD, 16'hC000, 8'h00));
        drain();

        // random phases over several settings
        for (pass_no = 0; pass_no < 13; pass_no++) begin
            write_reg(REG_MAPPER, (pass_no == 12) ? 32'hFFF : 32'(pass_no % 5));
            write_reg(REG_PRG_ROM, (pass_no % 4 == 0) ? 32'h3FFFFFF :
                                   (pass_no % 4 == 1) ? 32'd0 : 32'($urandom_range(1, 32)) * 32'h4000);
            write_reg(REG_CHR_ROM, (pass_no % 3 == 0) ? 32'h1FFFFFF :
                                   (pass_no % 3 == 1) ? 32'd0 : 32'($urandom_range(1, 16)) * 32'h2000);
            write_reg(REG_PRG_RAM, (pass_no % 2) ? 32'h3FFFFF : 32'($urandom_range(0, 2)) * 32'h1000);
            write_reg(REG_CHR_RAM, 32'(pass_no % 2));
            write_reg(REG_INIT_MIR, 32'($urandom_range(1)));
            write_reg(REG_PRG_COUNT, (pass_no % 3 == 0) ? 32'd255 : 32'($urandom_range(2)));
            write_reg(3'd7, 32'($urandom));
            if (pass_no == 0) begin send_idle_pct = 33; recv_idle_pct = 64; end
            if (pass_no == 4) begin send_idle_pct = 64; recv_idle_pct = 33; end
            if (pass_no == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
            if (pass_no == 6) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (40) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (k = 0; k < 48; k++) send_beat(rand_access());
            drain();
        end

        if (mismatches == 0 && unexpected == 0 && expected_beats.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
